>>> rtl/core/sbbp_pkg.sv
// ----------------------------------------------------------------------------
// sbbp_pkg
// Shared types and constants of the seven-bit byte packer.
// ----------------------------------------------------------------------------
`default_nettype none

package sbbp_pkg;

    localparam int unsigned PACK_GROUP   = 8;
    localparam int unsigned UNPACK_GROUP = 7;
    localparam int unsigned Q_DEPTH      = 4;
    localparam int unsigned Q_AW         = $clog2(Q_DEPTH);

    localparam logic DIR_PACK   = 1'b0;
    localparam logic DIR_UNPACK = 1'b1;

    typedef struct packed {
        logic [7:0] byte_a;
        logic [7:0] byte_b;
        logic [7:0] byte_c;
        logic [1:0] n_direct;
        logic [3:0] n_total;
        logic       eos;
    } job_t;

endpackage

`default_nettype wire

>>> rtl/core/sbbp_front.sv
// ----------------------------------------------------------------------------
// sbbp_front
// Accepts input items, runs the bit accumulator and turns each item that yields output into a job.
// ----------------------------------------------------------------------------
`default_nettype none

module sbbp_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic          cfg_data,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [7:0]    s_tdata,
    input  wire logic          s_tlast,
    input  wire logic          q_full,
    output logic               push,
    output sbbp_pkg::job_t     job
);
    import sbbp_pkg::*;

    logic        dir_reg,  dir_next;
    logic [13:0] buf_reg,  buf_next;
    logic [3:0]  cnt_reg,  cnt_next;
    logic [2:0]  pos_reg,  pos_next;

    logic        accept;

    assign cfg_ready = 1'b1;
    assign s_tready  = !q_full;
    assign accept    = s_tvalid && s_tready;

    always_comb begin
        logic [13:0] nb;
        logic [13:0] sh;
        logic [3:0]  nc;
        logic [3:0]  rem;
        logic [2:0]  p_new;
        logic [2:0]  last_pos;
        logic [1:0]  nd;
        logic [3:0]  nflush;
        logic [7:0]  ta;
        logic [6:0]  t7;

        job       = '0;
        dir_next  = dir_reg;
        buf_next  = buf_reg;
        cnt_next  = cnt_reg;
        pos_next  = pos_reg;
        nd        = 2'd0;
        sh        = '0;
        ta        = '0;
        t7        = '0;

        if (dir_reg == DIR_PACK) begin
            nb       = {buf_reg[6:0], s_tdata[7:1]};
            nc       = cnt_reg + 4'd7;
            rem      = nc;
            if (nc >= 4'd8) begin
                sh         = nb >> (nc - 4'd8);
                job.byte_a = sh[7:0];
                nd         = 2'd1;
                rem        = nc - 4'd8;
            end
            ta         = nb[7:0];
            job.byte_c = ta << (4'd8 - rem);
            last_pos   = 3'(PACK_GROUP - 1);
        end else begin
            nb       = {buf_reg[5:0], s_tdata};
            nc       = cnt_reg + 4'd8;
            sh       = nb >> (nc - 4'd7);
            job.byte_a = {sh[6:0], 1'b0};
            nd       = 2'd1;
            rem      = nc - 4'd7;
            if (rem >= 4'd7) begin
                sh         = nb >> (rem - 4'd7);
                job.byte_b = {sh[6:0], 1'b0};
                nd         = 2'd2;
                rem        = rem - 4'd7;
            end
            t7         = nb[6:0];
            t7         = t7 << (4'd7 - rem);
            job.byte_c = {t7, 1'b0};
            last_pos   = 3'(UNPACK_GROUP - 1);
        end

        p_new  = (pos_reg == last_pos) ? 3'd0 : pos_reg + 3'd1;
        nflush = (s_tlast && p_new != 3'd0) ? 4'd8 - {1'b0, p_new} : 4'd0;

        job.n_direct = nd;
        job.n_total  = {2'b00, nd} + nflush;
        job.eos      = s_tlast;

        if (accept) begin
            if (s_tlast) begin
                buf_next = '0;
                cnt_next = '0;
                pos_next = '0;
            end else begin
                buf_next = nb;
                cnt_next = rem;
                pos_next = p_new;
            end
        end

        if (cfg_valid && cfg_ready) begin
            dir_next = cfg_data;
            buf_next = '0;
            cnt_next = '0;
            pos_next = '0;
        end
    end

    assign push = accept && (job.n_total != 4'd0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dir_reg <= DIR_PACK;
            buf_reg <= '0;
            cnt_reg <= '0;
            pos_reg <= '0;
        end else begin
            dir_reg <= dir_next;
            buf_reg <= buf_next;
            cnt_reg <= cnt_next;
            pos_reg <= pos_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/sbbp_queue.sv
// ----------------------------------------------------------------------------
// sbbp_queue
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module sbbp_queue (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  wire sbbp_pkg::job_t push_job,
    input  wire logic           pop,
    output sbbp_pkg::job_t      head,
    output logic                full,
    output logic                empty
);
    import sbbp_pkg::*;

    job_t              mem [Q_DEPTH];
    logic [Q_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_AW:0]     count_reg,  count_next;

    assign full  = (count_reg == (Q_AW+1)'(Q_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full && !pop))
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && empty))
        else $error("pop from empty queue");

    a_count_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count lost a push");

endmodule

`default_nettype wire

>>> rtl/core/sbbp_back.sv
// ----------------------------------------------------------------------------
// sbbp_back
// Walks each job and drives result items through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sbbp_back (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire sbbp_pkg::job_t head,
    input  wire logic           q_empty,
    output logic                pop,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic [7:0]          m_tdata,
    output logic                m_tlast,
    output logic                m_tuser
);
    import sbbp_pkg::*;

    logic       m_tvalid_reg, m_tvalid_next;
    logic [7:0] m_tdata_reg,  m_tdata_next;
    logic       m_tlast_reg,  m_tlast_next;
    logic       m_tuser_reg,  m_tuser_next;
    logic [2:0] idx_reg,      idx_next;

    logic       out_free;
    logic       is_last;
    logic [7:0] sel_byte;

    assign out_free = !m_tvalid_reg || m_tready;
    assign is_last  = ({1'b0, idx_reg} == head.n_total - 4'd1);

    always_comb begin
        if ({1'b0, idx_reg} < {1'b0, head.n_direct}) begin
            sel_byte = idx_reg[0] ? head.byte_b : head.byte_a;
        end else if ({1'b0, idx_reg} == {1'b0, head.n_direct}) begin
            sel_byte = head.byte_c;
        end else begin
            sel_byte = '0;
        end
    end

    always_comb begin
        pop           = 1'b0;
        idx_next      = idx_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        m_tuser_next  = m_tuser_reg;
        if (out_free && !q_empty) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = sel_byte;
            m_tlast_next  = is_last;
            m_tuser_next  = is_last && head.eos;
            if (is_last) begin
                pop      = 1'b1;
                idx_next = '0;
            end else begin
                idx_next = idx_reg + 3'd1;
            end
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
            idx_reg      <= '0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
            idx_reg      <= idx_next;
        end
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

    a_done_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("stream end without run end");

    a_idx_in_job: assert property (@(posedge aclk) disable iff (!aresetn)
        !q_empty |-> ({1'b0, idx_reg} < head.n_total))
        else $error("job index past job length");

    a_idx_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        q_empty |-> (idx_reg == '0))
        else $error("job index left over with empty queue");

endmodule

`default_nettype wire

>>> rtl/core/seven_bit_byte_packer.sv
// ----------------------------------------------------------------------------
// seven_bit_byte_packer
// Packs septets into bytes (direction 0) or unpacks bytes into septets (1).
// ----------------------------------------------------------------------------
// Path: a taken item is written into the job queue, and the back loads its first result into the output register.
// Throughput: one item per cycle while the four-entry job queue has room;
//   results leave one per cycle while m_tready is held, and unpacking turns
//   every seven items into eight results.
// Reset: direction to pack, accumulator and group position cleared, job
//   queue empty, no result pending.
`default_nettype none

module seven_bit_byte_packer (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic       cfg_data,     // direction
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,      // [7:0] data_byte
    input  wire logic       s_tlast,      // end_of_stream
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,      // [7:0] out_byte
    output logic            m_tlast,      // run_last
    output logic            m_tuser       // [0] stream_done
);
    import sbbp_pkg::*;

    job_t push_job;
    job_t head;
    logic push;
    logic pop;
    logic q_full;
    logic q_empty;

    sbbp_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .q_full    (q_full),
        .push      (push),
        .job       (push_job)
    );

    sbbp_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .full     (q_full),
        .empty    (q_empty)
    );

    sbbp_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .q_empty  (q_empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire
